// ===== hdl/lobt_pkg.sv =====
// Package for the limit order book tracker: codes, default sizes,
// the classified request type and the result type.
// No dependencies.
`timescale 1ns / 1ps

package lobt_pkg;

   localparam int DEF_MAX_ORDERS = 4096;
   localparam int DEF_MAX_LEVELS = 1024;
   localparam int DEF_MAX_STOCKS = 256;

   localparam int QTY_W = 44;

   localparam logic [7:0] SIDE_BUY_CODE  = 8'd66;
   localparam logic [7:0] SIDE_SELL_CODE = 8'd83;

   localparam logic [2:0] ACT_ADD     = 3'd0;
   localparam logic [2:0] ACT_REDUCE  = 3'd1;
   localparam logic [2:0] ACT_DELETE  = 3'd2;
   localparam logic [2:0] ACT_REPLACE = 3'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DUP     = 3'd1;
   localparam logic [2:0] ST_SIDE    = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_OVER    = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_REDUCE,
      OP_DELETE,
      OP_REPLACE,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  stock;
      logic [63:0] orig_ref;
      logic [63:0] new_ref;
      logic        side_ok;
      logic        side_sell;
      logic [31:0] share_count;
      logic [31:0] limit_price;
   } lobt_item_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [7:0]       stock;
      logic             bid_present;
      logic [31:0]      top_bid;
      logic             ask_present;
      logic [31:0]      top_ask;
      logic             crossed;
      logic [QTY_W-1:0] bid_quantity;
      logic [QTY_W-1:0] ask_quantity;
   } lobt_result_type;

endpackage

// ===== hdl/lobt_if.sv =====
// Request and response channel interfaces of the order book tracker.
// Depends on lobt_pkg for the quantity width.
`timescale 1ns / 1ps

interface lobt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  locate;
   logic [63:0] orig_ref;
   logic [63:0] new_ref;
   logic [7:0]  side_code;
   logic [31:0] share_count;
   logic [31:0] limit_price;

   modport source (output valid, action, locate, orig_ref, new_ref, side_code,
                   share_count, limit_price, input ready);
   modport sink (input valid, action, locate, orig_ref, new_ref, side_code,
                 share_count, limit_price, output ready);
endinterface

interface lobt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 status;
   logic [7:0]                 stock;
   logic                       bid_present;
   logic [31:0]                top_bid;
   logic                       ask_present;
   logic [31:0]                top_ask;
   logic                       crossed;
   logic [lobt_pkg::QTY_W-1:0] bid_quantity;
   logic [lobt_pkg::QTY_W-1:0] ask_quantity;

   modport source (output valid, status, stock, bid_present, top_bid, ask_present,
                   top_ask, crossed, bid_quantity, ask_quantity, input ready);
   modport sink (input valid, status, stock, bid_present, top_bid, ask_present,
                 top_ask, crossed, bid_quantity, ask_quantity, output ready);
endinterface

// ===== hdl/lobt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lobt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lobt_front.sv =====
// Front end: accepts requests, decodes action and side, reduces the locate
// to a stock index and queues the classified request. Depends on lobt_pkg, lobt_if.
`timescale 1ns / 1ps

module lobt_front #(
   parameter int MAX_STOCKS = lobt_pkg::DEF_MAX_STOCKS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    hold,
   lobt_req_if.sink                req_bus,
   output lobt_pkg::lobt_item_type item,
   output logic                    item_valid,
   input  logic                    item_ready
);
   import lobt_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QPW = $clog2(QDEPTH);

   logic [7:0]    stock_lut [256];
   lobt_item_type cls;
   lobt_item_type q_ff [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPW:0]   count_ff;
   logic           push, pop;

   // Stock index is the locate modulo the stock count, from a constant table.
   for (genvar k = 0; k < 256; k++) begin : g_lut
      assign stock_lut[k] = 8'(k % MAX_STOCKS);
   end

   always_comb begin
      cls = '0;
      case (req_bus.action)
         ACT_ADD:     cls.op = OP_ADD;
         ACT_REDUCE:  cls.op = OP_REDUCE;
         ACT_DELETE:  cls.op = OP_DELETE;
         ACT_REPLACE: cls.op = OP_REPLACE;
         default:     cls.op = OP_QUERY;
      endcase
      cls.stock       = stock_lut[req_bus.locate];
      cls.orig_ref    = req_bus.orig_ref;
      cls.new_ref     = req_bus.new_ref;
      cls.side_ok     = (req_bus.side_code == SIDE_BUY_CODE) ||
                        (req_bus.side_code == SIDE_SELL_CODE);
      cls.side_sell   = (req_bus.side_code == SIDE_SELL_CODE);
      cls.share_count = req_bus.share_count;
      cls.limit_price = req_bus.limit_price;
   end

   assign req_bus.ready = !hold && (count_ff != (QPW+1)'(QDEPTH));
   assign push = req_bus.valid && req_bus.ready;
   assign item_valid = (count_ff != '0);
   assign pop = item_valid && item_ready;
   assign item = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QPW+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPW+1)'(1);
         end
      end
   end

endmodule

// ===== hdl/lobt_back.sv =====
// Back end: sequencer over the order, level and side total memories that
// applies one request and builds its response. Depends on lobt_pkg, lobt_if, lobt_ram.
`timescale 1ns / 1ps

module lobt_back #(
   parameter int MAX_ORDERS = lobt_pkg::DEF_MAX_ORDERS,
   parameter int MAX_LEVELS = lobt_pkg::DEF_MAX_LEVELS,
   parameter int MAX_STOCKS = lobt_pkg::DEF_MAX_STOCKS
) (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    clearing,
   input  lobt_pkg::lobt_item_type item,
   input  logic                    item_valid,
   output logic                    item_ready,
   lobt_rsp_if.source              rsp_bus
);
   import lobt_pkg::*;

   localparam int OW   = $clog2(MAX_ORDERS);
   localparam int LW   = $clog2(MAX_LEVELS);
   localparam int PW   = $clog2(2 * MAX_STOCKS);
   localparam int NW   = OW + 1;
   localparam int TOTN = 2 * MAX_STOCKS;
   localparam int CLRA = (MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS;
   localparam int CLRN = (CLRA > TOTN) ? CLRA : TOTN;
   localparam int CTW  = $clog2(CLRN) + 1;

   typedef struct packed {
      logic          used;
      logic [63:0]   key;
      logic [31:0]   price;
      logic [31:0]   remaining;
      logic [PW-1:0] place;
   } oword_type;

   typedef struct packed {
      logic          used;
      logic [PW-1:0] place;
      logic [31:0]   price;
      logic [NW-1:0] orders;
   } lword_type;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_OSCAN = 10'b0000000100,
      S_LSCAN = 10'b0000001000,
      S_WR1   = 10'b0000010000,
      S_WR2   = 10'b0000100000,
      S_TOT0  = 10'b0001000000,
      S_TOT1  = 10'b0010000000,
      S_TOT2  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [CTW-1:0] cnt_ff, cnt_in, pidx_ff;
   logic           pv_ff;
   lobt_item_type  item_ff;

   // Order scan results.
   logic          a_hit_ff, b_dup_ff, f_hit_ff;
   logic [OW-1:0] a_idx_ff, f_idx_ff;
   logic [31:0]   a_price_ff, a_rem_ff;
   logic [PW-1:0] a_place_ff;

   // Level scan results.
   logic          lr_hit_ff, lr_used_ff, li_hit_ff, lf_hit_ff;
   logic [LW-1:0] lr_idx_ff, li_idx_ff, lf_idx_ff;
   logic [NW-1:0] lr_cnt_ff, li_cnt_ff;
   logic          bid_has_ff, ask_has_ff;
   logic [31:0]   bid_ff, ask_ff;
   logic [QTY_W-1:0] btot_ff;

   lobt_result_type res_ff, rsp_ff;
   logic            rsp_valid_ff;

   // Memory ports.
   logic             o_we, l_we, t_we;
   logic [OW-1:0]    o_waddr;
   logic [LW-1:0]    l_waddr;
   logic [PW-1:0]    t_waddr, t_raddr;
   oword_type        o_wdata, o_rdata;
   lword_type        l_wdata, l_rdata;
   logic [QTY_W-1:0] t_wdata, t_rdata;

   // Decisions taken from the order scan.
   logic [2:0]    status_pre, status_fin;
   logic [7:0]    rstock;
   logic          rem_act, ord_rem_en, ord_rem_used, ins_try, ins_ok, tot_en;
   logic [31:0]   ord_rem_val, tot_sub, tot_add;
   logic [PW-1:0] ins_place, tot_place, bid_place, ask_place;
   logic [63:0]   ins_ref;
   logic [QTY_W-1:0] tot_new;

   // Per-entry scan terms.
   logic          o_hit, o_dup, o_free;
   logic          l_mr, l_ua, l_mi;
   logic [NW-1:0] l_ca;
   logic          last_o, last_l;

   lobt_ram #(.WIDTH($bits(oword_type)), .DEPTH(MAX_ORDERS)) u_order_ram (
      .clock(clock), .wr_en(o_we), .wr_addr(o_waddr), .wr_data(o_wdata),
      .rd_addr(cnt_ff[OW-1:0]), .rd_data(o_rdata)
   );

   lobt_ram #(.WIDTH($bits(lword_type)), .DEPTH(MAX_LEVELS)) u_level_ram (
      .clock(clock), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_addr(cnt_ff[LW-1:0]), .rd_data(l_rdata)
   );

   lobt_ram #(.WIDTH(QTY_W), .DEPTH(TOTN)) u_total_ram (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_addr(t_raddr), .rd_data(t_rdata)
   );

   assign clearing   = (state_ff == S_CLEAR);
   assign item_ready = (state_ff == S_IDLE);
   assign last_o     = (cnt_ff == CTW'(MAX_ORDERS));
   assign last_l     = (cnt_ff == CTW'(MAX_LEVELS));

   always_comb begin
      status_pre   = ST_OK;
      rstock       = item_ff.stock;
      rem_act      = 1'b0;
      ord_rem_en   = 1'b0;
      ord_rem_used = 1'b0;
      ord_rem_val  = a_rem_ff;
      ins_try      = 1'b0;
      ins_place    = PW'({item_ff.stock, item_ff.side_sell});
      ins_ref      = item_ff.orig_ref;
      tot_sub      = '0;
      case (item_ff.op)
         OP_ADD: begin
            if (a_hit_ff) begin
               status_pre = ST_DUP;
            end else if (!item_ff.side_ok) begin
               status_pre = ST_SIDE;
            end else begin
               ins_try = 1'b1;
            end
         end
         OP_REDUCE: begin
            if (!a_hit_ff) begin
               status_pre = ST_UNKNOWN;
            end else begin
               rstock = 8'(a_place_ff >> 1);
               if (item_ff.share_count > a_rem_ff) begin
                  status_pre = ST_OVER;
               end else begin
                  ord_rem_en   = 1'b1;
                  ord_rem_val  = a_rem_ff - item_ff.share_count;
                  ord_rem_used = (ord_rem_val != '0);
                  rem_act      = !ord_rem_used;
                  tot_sub      = item_ff.share_count;
               end
            end
         end
         OP_DELETE: begin
            if (!a_hit_ff) begin
               status_pre = ST_UNKNOWN;
            end else begin
               rstock     = 8'(a_place_ff >> 1);
               ord_rem_en = 1'b1;
               rem_act    = 1'b1;
               tot_sub    = a_rem_ff;
            end
         end
         OP_REPLACE: begin
            if (!a_hit_ff) begin
               status_pre = ST_UNKNOWN;
            end else begin
               rstock     = 8'(a_place_ff >> 1);
               ord_rem_en = 1'b1;
               rem_act    = 1'b1;
               tot_sub    = a_rem_ff;
               ins_place  = a_place_ff;
               ins_ref    = item_ff.new_ref;
               if (b_dup_ff) begin
                  status_pre = ST_DUP;
               end else begin
                  ins_try = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // The insert needs a free order slot and a matching or free level slot.
   assign ins_ok     = ins_try && f_hit_ff && (li_hit_ff || lf_hit_ff);
   assign status_fin = (ins_try && !ins_ok) ? ST_FULL : status_pre;
   assign tot_en     = ord_rem_en || ins_ok;
   assign tot_add    = ins_ok ? item_ff.share_count : '0;
   assign tot_place  = (item_ff.op == OP_ADD) ? ins_place : a_place_ff;
   assign bid_place  = PW'({rstock, 1'b0});
   assign ask_place  = PW'({rstock, 1'b1});
   assign tot_new    = (tot_place[0] ? t_rdata : btot_ff) + QTY_W'(tot_add)
                       - QTY_W'(tot_sub);

   always_comb begin
      o_hit  = o_rdata.used && (o_rdata.key == item_ff.orig_ref);
      o_dup  = o_rdata.used && (o_rdata.key == item_ff.new_ref) &&
               (o_rdata.key != item_ff.orig_ref);
      // An original that a replace removes counts as free for its new order.
      o_free = !o_rdata.used || (o_rdata.key == item_ff.orig_ref);
      l_mr   = l_rdata.used && rem_act && (l_rdata.place == a_place_ff) &&
               (l_rdata.price == a_price_ff);
      l_ua   = l_rdata.used && !(l_mr && (l_rdata.orders == NW'(1)));
      l_ca   = l_rdata.orders - NW'(l_mr);
      l_mi   = ins_try && l_ua && (l_rdata.place == ins_place) &&
               (l_rdata.price == item_ff.limit_price);
   end

   always_comb begin
      o_we    = 1'b0;
      o_waddr = cnt_ff[OW-1:0];
      o_wdata = '0;
      l_we    = 1'b0;
      l_waddr = cnt_ff[LW-1:0];
      l_wdata = '0;
      t_we    = 1'b0;
      t_waddr = cnt_ff[PW-1:0];
      t_wdata = '0;
      t_raddr = (state_ff == S_TOT0) ? bid_place : ask_place;
      case (state_ff)
         S_CLEAR: begin
            o_we = (cnt_ff < CTW'(MAX_ORDERS));
            l_we = (cnt_ff < CTW'(MAX_LEVELS));
            t_we = (cnt_ff < CTW'(TOTN));
         end
         S_WR1: begin
            o_we    = ord_rem_en;
            o_waddr = a_idx_ff;
            o_wdata = '{used: ord_rem_used, key: item_ff.orig_ref, price: a_price_ff,
                        remaining: ord_rem_val, place: a_place_ff};
            l_we    = lr_hit_ff;
            l_waddr = lr_idx_ff;
            l_wdata = '{used: lr_used_ff, place: a_place_ff, price: a_price_ff,
                        orders: lr_cnt_ff};
         end
         S_WR2: begin
            o_we    = ins_ok;
            o_waddr = f_idx_ff;
            o_wdata = '{used: 1'b1, key: ins_ref, price: item_ff.limit_price,
                        remaining: item_ff.share_count, place: ins_place};
            l_we    = ins_ok;
            l_waddr = li_hit_ff ? li_idx_ff : lf_idx_ff;
            l_wdata = '{used: 1'b1, place: ins_place, price: item_ff.limit_price,
                        orders: li_hit_ff ? li_cnt_ff + NW'(1) : NW'(1)};
         end
         S_TOT2: begin
            t_we    = tot_en;
            t_waddr = tot_place;
            t_wdata = tot_new;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + CTW'(1);
            if (cnt_ff == CTW'(CLRN - 1)) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               state_in = S_OSCAN;
               cnt_in   = '0;
            end
         end
         S_OSCAN: begin
            if (!last_o) begin
               cnt_in = cnt_ff + CTW'(1);
            end else if (!pv_ff) begin
               state_in = S_LSCAN;
               cnt_in   = '0;
            end
         end
         S_LSCAN: begin
            if (!last_l) begin
               cnt_in = cnt_ff + CTW'(1);
            end else if (!pv_ff) begin
               state_in = S_WR1;
            end
         end
         S_WR1:  state_in = S_WR2;
         S_WR2:  state_in = S_TOT0;
         S_TOT0: state_in = S_TOT1;
         S_TOT1: state_in = S_TOT2;
         S_TOT2: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= ((state_ff == S_OSCAN) && !last_o) ||
                     ((state_ff == S_LSCAN) && !last_l);
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= cnt_ff;
      case (state_ff)
         S_IDLE: begin
            item_ff    <= item;
            a_hit_ff   <= 1'b0;
            b_dup_ff   <= 1'b0;
            f_hit_ff   <= 1'b0;
            lr_hit_ff  <= 1'b0;
            li_hit_ff  <= 1'b0;
            lf_hit_ff  <= 1'b0;
            bid_has_ff <= 1'b0;
            ask_has_ff <= 1'b0;
            bid_ff     <= '0;
            ask_ff     <= '0;
         end
         S_OSCAN: begin
            if (pv_ff) begin
               if (o_hit) begin
                  a_hit_ff   <= 1'b1;
                  a_idx_ff   <= pidx_ff[OW-1:0];
                  a_price_ff <= o_rdata.price;
                  a_rem_ff   <= o_rdata.remaining;
                  a_place_ff <= o_rdata.place;
               end
               if (o_dup) begin
                  b_dup_ff <= 1'b1;
               end
               if (o_free && !f_hit_ff) begin
                  f_hit_ff <= 1'b1;
                  f_idx_ff <= pidx_ff[OW-1:0];
               end
            end
         end
         S_LSCAN: begin
            if (pv_ff) begin
               if (l_mr) begin
                  lr_hit_ff  <= 1'b1;
                  lr_idx_ff  <= pidx_ff[LW-1:0];
                  lr_used_ff <= l_ua;
                  lr_cnt_ff  <= l_ca;
               end
               if (l_mi) begin
                  li_hit_ff <= 1'b1;
                  li_idx_ff <= pidx_ff[LW-1:0];
                  li_cnt_ff <= l_ca;
               end
               if (!l_ua && !lf_hit_ff) begin
                  lf_hit_ff <= 1'b1;
                  lf_idx_ff <= pidx_ff[LW-1:0];
               end
               if (l_ua && (l_rdata.place == bid_place)) begin
                  bid_has_ff <= 1'b1;
                  if (!bid_has_ff || (l_rdata.price > bid_ff)) begin
                     bid_ff <= l_rdata.price;
                  end
               end
               if (l_ua && (l_rdata.place == ask_place)) begin
                  ask_has_ff <= 1'b1;
                  if (!ask_has_ff || (l_rdata.price < ask_ff)) begin
                     ask_ff <= l_rdata.price;
                  end
               end
            end
         end
         S_TOT1: begin
            btot_ff <= t_rdata;
         end
         default: begin
         end
      endcase
   end

   // Result: the level scan view plus the level that the insert adds.
   always_ff @(posedge clock) begin
      logic        bh, ah;
      logic [31:0] bp, ap;
      bh = bid_has_ff;
      bp = bid_ff;
      ah = ask_has_ff;
      ap = ask_ff;
      if (ins_ok && !ins_place[0] && (!bid_has_ff || (item_ff.limit_price > bid_ff))) begin
         bp = item_ff.limit_price;
      end
      if (ins_ok && ins_place[0] && (!ask_has_ff || (item_ff.limit_price < ask_ff))) begin
         ap = item_ff.limit_price;
      end
      bh = bh || (ins_ok && !ins_place[0]);
      ah = ah || (ins_ok && ins_place[0]);
      if (state_ff == S_TOT2) begin
         res_ff.status       <= status_fin;
         res_ff.stock        <= rstock;
         res_ff.bid_present  <= bh;
         res_ff.top_bid      <= bp;
         res_ff.ask_present  <= ah;
         res_ff.top_ask      <= ap;
         res_ff.crossed      <= bh && ah && (bp >= ap);
         res_ff.bid_quantity <= (tot_en && !tot_place[0]) ? tot_new : btot_ff;
         res_ff.ask_quantity <= (tot_en && tot_place[0]) ? tot_new : t_rdata;
      end
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready)) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_ff.status;
   assign rsp_bus.stock        = rsp_ff.stock;
   assign rsp_bus.bid_present  = rsp_ff.bid_present;
   assign rsp_bus.top_bid      = rsp_ff.top_bid;
   assign rsp_bus.ask_present  = rsp_ff.ask_present;
   assign rsp_bus.top_ask      = rsp_ff.top_ask;
   assign rsp_bus.crossed      = rsp_ff.crossed;
   assign rsp_bus.bid_quantity = rsp_ff.bid_quantity;
   assign rsp_bus.ask_quantity = rsp_ff.ask_quantity;

`ifndef ASSERT_OFF
   a_reset_clears : assert property (@(posedge clock) reset |=> state_ff == S_CLEAR)
      else $error("sequencer did not start the clearing pass after reset");
   a_crossed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.crossed || (rsp_ff.bid_present && rsp_ff.ask_present)))
      else $error("crossed flag without both sides present");
   a_bid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.bid_present |-> rsp_ff.top_bid == '0)
      else $error("absent bid reported with a nonzero price");
   a_full_only_insert : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TOT2) && (status_fin == ST_FULL) |-> ins_try && !ins_ok)
      else $error("table full reported without a failed insert");
`endif

endmodule

// ===== hdl/limit_order_book_tracker.sv =====
// Top level of the limit order book tracker: front end, request queue
// and back-end sequencer. Depends on lobt_pkg, lobt_if, lobt_front, lobt_back.
`timescale 1ns / 1ps

// The tracker keeps resting orders and price levels per stock and side, and
// answers every request with one response carrying a status and the book
// summary of one stock (best bid, best ask, crossed flag, side totals).
// After reset the block runs a clearing pass over max(MAX_ORDERS, MAX_LEVELS,
// 2*MAX_STOCKS) addresses, during which it takes no request. For each
// request the back end walks the whole order memory once to find the
// reference, the new reference and a free slot, then walks the whole level
// memory once to update the level, find a free level and search the best
// prices, both at one read per cycle through the single read port of each
// memory. A two-entry queue after the front end takes new requests while
// the back end is busy, and the response register lets the next request
// start while a response waits to be taken.
module limit_order_book_tracker #(
   parameter int MAX_ORDERS = lobt_pkg::DEF_MAX_ORDERS,
   parameter int MAX_LEVELS = lobt_pkg::DEF_MAX_LEVELS,
   parameter int MAX_STOCKS = lobt_pkg::DEF_MAX_STOCKS
) (
   input logic        clock,
   input logic        reset,
   lobt_req_if.sink   req_bus,
   lobt_rsp_if.source rsp_bus
);
   import lobt_pkg::*;

   lobt_item_type item;
   logic          item_valid;
   logic          item_ready;
   logic          clearing;

   // The front end decodes and queues; it holds off while memories clear.
   lobt_front #(.MAX_STOCKS(MAX_STOCKS)) u_front (
      .clock(clock), .reset(reset), .hold(clearing), .req_bus(req_bus),
      .item(item), .item_valid(item_valid), .item_ready(item_ready)
   );

   // The back end applies one request at a time and drives the response.
   lobt_back #(
      .MAX_ORDERS(MAX_ORDERS), .MAX_LEVELS(MAX_LEVELS), .MAX_STOCKS(MAX_STOCKS)
   ) u_back (
      .clock(clock), .reset(reset), .clearing(clearing), .item(item),
      .item_valid(item_valid), .item_ready(item_ready), .rsp_bus(rsp_bus)
   );

endmodule
